// File: hw/rtl/pflh_pkg.sv
// ----------------------------------------------------------------------------
// pflh_pkg
// Shared types and constants of the pocket floppy link handshake core.
// ----------------------------------------------------------------------------
package pflh_pkg;

   // Queue sizing default
   localparam int QUEUE_DEPTH_DEFAULT = 256;

   // Control/status register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HOLD_MS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLUSH_IDLE_MS = 2'd2;

   // Register reset values
   localparam logic [7:0] DEVICE_ID_RESET     = 8'h41;
   localparam logic [7:0] START_HOLD_RESET    = 8'd40;
   localparam logic [9:0] FLUSH_IDLE_RESET    = 10'd50;

   // Millisecond timers
   localparam logic [9:0]  EVT_MAX       = 10'd1023;
   localparam logic [11:0] LED_MS        = 12'd3000;
   localparam logic [9:0]  ACK_GAP_MS    = 10'd2;
   localparam logic [9:0]  END_PULSE_MS  = 10'd9;
   localparam logic [9:0]  TX_GAP_MS     = 10'd5;

   typedef struct packed {
      logic       action;
      logic       line_busy;
      logic       pin_data_out;
      logic       pin_motor_out1;
      logic       line_sel1;
      logic       line_sel2;
      logic       pin_data_in;
      logic       tick_ms;
      logic [7:0] response_byte;
   } req_type;

   typedef struct packed {
      logic       ack_level;
      logic       drive_valid;
      logic       drive_sel1;
      logic       drive_sel2;
      logic       drive_data_out;
      logic       drive_data_in;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       command_end;
      logic       activity_led;
      logic       queue_full;
   } rsp_type;

endpackage

// File: hw/rtl/pflh_ifs.sv
// ----------------------------------------------------------------------------
// pflh request and response channels
// Valid/ready channels carrying one request or one response each.
// ----------------------------------------------------------------------------
interface pflh_req_if;
   logic              valid;
   logic              ready;
   pflh_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pflh_rsp_if;
   logic              valid;
   logic              ready;
   pflh_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/pocket_floppy_link_handshake_core.sv
// ----------------------------------------------------------------------------
// pocket_floppy_link_handshake_core
// Peripheral side of an 11-pin pocket-computer link: selection, nibble
// exchange and response byte queue.
// ----------------------------------------------------------------------------
// Every request yields exactly one response. A new request is taken in every
// cycle as long as responses are taken; a request sits in the input register,
// is evaluated in one pass and lands in the response register, from which its
// response is offered. Pin samples run the selection phase machine and then
// the nibble exchange; load requests append a byte to the response queue, a
// QUEUE_DEPTH-entry memory with one write and one registered read port. The
// read port always looks up the entry that will be at the head of the queue,
// and a one-entry bypass covers a write to that entry in the same cycle. Queue
// entries need no clearing after reset, so requests are taken right after
// reset. Configuration writes go straight to the registers and must only
// happen while the core is idle.
// ----------------------------------------------------------------------------
module pocket_floppy_link_handshake_core #(
   parameter int QUEUE_DEPTH = pflh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   pflh_req_if.sink                            req_chan,
   pflh_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [pflh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pflh_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_ENTRY = PW'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HOLD  = 3'd1,
      PH_CODE  = 3'd2,
      PH_GAP   = 3'd3,
      PH_MATCH = 3'd4,
      PH_END   = 3'd5
   } phase_type;

   // Configuration registers
   logic [7:0] device_id_ff;
   logic [7:0] start_hold_ff;
   logic [9:0] flush_idle_ff;

   // Input and response registers
   logic              in_valid_ff, in_valid_in;
   pflh_pkg::req_type in_ff;
   logic              out_valid_ff, out_valid_in;
   pflh_pkg::rsp_type rsp_ff;
   logic              advance;

   // Link state
   phase_type    phase_ff, phase_in;
   logic [7:0]   shift_ff, shift_in;
   logic [2:0]   bitcnt_ff, bitcnt_in;
   logic [7:0]   selcode_ff, selcode_in;
   logic         ack_ff, ack_in;
   logic         pbusy_ff, pbusy_in;
   logic [9:0]   evt_ff, evt_in;
   logic [11:0]  act_ff, act_in;
   logic         rxhalf_ff, rxhalf_in;
   logic [3:0]   rxlow_ff, rxlow_in;
   logic         rxpend_ff, rxpend_in;
   logic         txhalf_ff, txhalf_in;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // Response queue memory with head prefetch
   logic [7:0]    queue_mem [QUEUE_DEPTH];
   logic [7:0]    rd_ff;
   logic [7:0]    byp_ff;
   logic          byp_hit_ff;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [PW-1:0] rd_addr;
   logic [CW:0]   tail_sum;
   logic [7:0]    front;

   pflh_pkg::rsp_type step;
   logic              rise, fall;
   logic [3:0]        nib, drv;

   // ---- handshake ----------------------------------------------------------
   // Advance the held request whenever the response slot is free or emptying.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // ---- queue addressing ---------------------------------------------------
   // Tail is head plus count, folded back once into the queue range.
   always_comb begin
      tail_sum = {1'b0, CW'(head_ff)} + {1'b0, count_ff};
      if (tail_sum >= {1'b0, DEPTH_C}) begin
         tail_sum = tail_sum - {1'b0, DEPTH_C};
      end
      wr_addr = tail_sum[PW-1:0];
   end

   // Look up the entry that will be the head in the next cycle.
   assign rd_addr = advance ? head_in : head_ff;
   assign front   = byp_hit_ff ? byp_ff : rd_ff;

   // ---- one pass over the held request -------------------------------------
   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      bitcnt_in  = bitcnt_ff;
      selcode_in = selcode_ff;
      ack_in     = ack_ff;
      pbusy_in   = pbusy_ff;
      evt_in     = evt_ff;
      act_in     = act_ff;
      rxhalf_in  = rxhalf_ff;
      rxlow_in   = rxlow_ff;
      rxpend_in  = rxpend_ff;
      txhalf_in  = txhalf_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      step       = '0;
      drv        = 4'd0;
      rise       = in_ff.line_busy && !pbusy_ff;
      fall       = !in_ff.line_busy && pbusy_ff;
      nib        = {in_ff.pin_data_in, in_ff.pin_data_out, in_ff.line_sel2, in_ff.line_sel1};

      // Both millisecond timers advance first, whatever the request.
      if (in_ff.tick_ms) begin
         if (evt_in < pflh_pkg::EVT_MAX) begin
            evt_in = evt_in + 10'd1;
         end
         if (act_in < pflh_pkg::LED_MS) begin
            act_in = act_in + 12'd1;
         end
      end

      if (in_ff.action) begin
         // Load: append or refuse, nothing else moves.
         if (count_ff < DEPTH_C) begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end else begin
            step.queue_full = 1'b1;
         end
      end else begin
         if (phase_ff != PH_IDLE) begin
            act_in = 12'd0;
         end

         // Selection phase machine
         case (phase_ff)
            PH_IDLE: begin
               if (in_ff.pin_motor_out1 && in_ff.pin_data_out) begin
                  evt_in   = 10'd0;
                  phase_in = PH_HOLD;
               end
            end
            PH_HOLD: begin
               if (in_ff.pin_motor_out1 && in_ff.pin_data_out) begin
                  if (evt_in > {2'b00, start_hold_ff}) begin
                     phase_in = PH_CODE;
                     ack_in   = 1'b1;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CODE: begin
               if (in_ff.line_busy) begin
                  shift_in  = {in_ff.pin_data_out, shift_ff[7:1]};
                  bitcnt_in = bitcnt_ff + 3'd1;
                  ack_in    = 1'b0;
                  if (bitcnt_in == 3'd0) begin
                     selcode_in = shift_in;
                     phase_in   = (shift_in == device_id_ff) ? PH_MATCH : PH_IDLE;
                  end else begin
                     phase_in = PH_GAP;
                     evt_in   = 10'd0;
                  end
               end
            end
            PH_GAP: begin
               if (evt_in > pflh_pkg::ACK_GAP_MS) begin
                  phase_in = PH_CODE;
                  ack_in   = 1'b1;
               end
            end
            PH_MATCH: begin
               if (!in_ff.line_busy && !in_ff.pin_motor_out1) begin
                  ack_in    = 1'b1;
                  phase_in  = PH_END;
                  evt_in    = 10'd0;
                  shift_in  = 8'd0;
                  bitcnt_in = 3'd0;
               end
            end
            PH_END: begin
               if (evt_in > pflh_pkg::END_PULSE_MS) begin
                  ack_in   = 1'b0;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // Nibble exchange while selected and the phase machine rests
         if (selcode_in == device_id_ff && phase_in == PH_IDLE) begin
            if (rise && !ack_in) begin
               if (rxhalf_ff) begin
                  step.rx_byte  = {nib, rxlow_ff};
                  step.rx_valid = 1'b1;
                  rxhalf_in     = 1'b0;
               end else begin
                  rxlow_in  = nib;
                  rxhalf_in = 1'b1;
               end
               rxpend_in = 1'b1;
               ack_in    = 1'b1;
               evt_in    = 10'd0;
               act_in    = 12'd0;
            end else if (fall && ack_in) begin
               ack_in = 1'b0;
               evt_in = 10'd0;
               act_in = 12'd0;
            end else if (count_ff != '0 && evt_in > pflh_pkg::TX_GAP_MS &&
                         !in_ff.line_busy && !ack_in) begin
               if (txhalf_ff) begin
                  drv       = front[7:4];
                  head_in   = (head_ff == LAST_ENTRY) ? '0 : head_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
                  txhalf_in = 1'b0;
               end else begin
                  drv       = front[3:0];
                  txhalf_in = 1'b1;
               end
               step.drive_valid = 1'b1;
               ack_in           = 1'b1;
               act_in           = 12'd0;
            end else if (ack_in && rise) begin
               ack_in = 1'b0;
               act_in = 12'd0;
            end else if (evt_in > flush_idle_ff && rxpend_ff) begin
               // Idle gap: close the command, drop any unpaired low nibble.
               step.command_end = 1'b1;
               rxpend_in        = 1'b0;
               rxhalf_in        = 1'b0;
               act_in           = 12'd0;
            end
         end
         pbusy_in = in_ff.line_busy;
      end

      step.drive_sel1     = drv[0];
      step.drive_sel2     = drv[1];
      step.drive_data_out = drv[2];
      step.drive_data_in  = drv[3];
      step.ack_level      = ack_in;
      step.activity_led   = act_in < pflh_pkg::LED_MS;
   end

   // ---- registers ----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff  <= pflh_pkg::DEVICE_ID_RESET;
         start_hold_ff <= pflh_pkg::START_HOLD_RESET;
         flush_idle_ff <= pflh_pkg::FLUSH_IDLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pflh_pkg::CSR_DEVICE_ID:     device_id_ff  <= csr_wdata[7:0];
            pflh_pkg::CSR_START_HOLD_MS: start_hold_ff <= csr_wdata[7:0];
            pflh_pkg::CSR_FLUSH_IDLE_MS: flush_idle_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         shift_ff     <= 8'd0;
         bitcnt_ff    <= 3'd0;
         selcode_ff   <= 8'd0;
         ack_ff       <= 1'b0;
         pbusy_ff     <= 1'b0;
         evt_ff       <= 10'd0;
         act_ff       <= pflh_pkg::LED_MS;
         rxhalf_ff    <= 1'b0;
         rxlow_ff     <= 4'd0;
         rxpend_ff    <= 1'b0;
         txhalf_ff    <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         byp_hit_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         byp_hit_ff   <= advance && wr_en && (wr_addr == rd_addr);
         if (advance) begin
            phase_ff   <= phase_in;
            shift_ff   <= shift_in;
            bitcnt_ff  <= bitcnt_in;
            selcode_ff <= selcode_in;
            ack_ff     <= ack_in;
            pbusy_ff   <= pbusy_in;
            evt_ff     <= evt_in;
            act_ff     <= act_in;
            rxhalf_ff  <= rxhalf_in;
            rxlow_ff   <= rxlow_in;
            rxpend_ff  <= rxpend_in;
            txhalf_ff  <= txhalf_in;
            head_ff    <= head_in;
            count_ff   <= count_in;
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_ff <= step;
      end
      byp_ff <= in_ff.response_byte;
   end

   // Queue memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         queue_mem[wr_addr] <= in_ff.response_byte;
      end
      rd_ff <= queue_mem[rd_addr];
   end

   // ---- assertions ---------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count beyond depth");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_chan.ready)
      else $error("request refused with empty response slot");

   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.action && count_ff != DEPTH_C
      |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("accepted load did not grow the queue");

   a_rx_pairs: assert property (@(posedge clock) disable iff (reset)
      advance && step.rx_valid |-> rxhalf_ff)
      else $error("byte completed without a held low nibble");

   a_drive_has_data: assert property (@(posedge clock) disable iff (reset)
      advance && step.drive_valid |-> count_ff != '0 && step.ack_level)
      else $error("nibble driven from an empty queue or without ACK");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pocket_floppy_link_handshake_core: pin samples and
// queue loads go in on the request channel, and every response is compared
// field by field with a cycle-free model of the link kept in this module.
// ----------------------------------------------------------------------------
module testbench;

   // Longest stretch with no handshake on either side before giving up; the
   // long receiver hold-off below is the slowest legitimate case.
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD_OFF = 300;
   // A response passes the input and response registers before it can be taken; settle longer.
   localparam int SETTLE_CYCLES = 8;

   // Selection phases of the link, as the core walks them.
   typedef enum logic [2:0] {
      SEL_IDLE      = 3'd0,
      SEL_HOLD      = 3'd1,
      SEL_BIT       = 3'd2,
      SEL_GAP       = 3'd3,
      SEL_MATCHED   = 3'd4,
      SEL_END_PULSE = 3'd5
   } sel_phase_type;

   logic clock = 1'b0;
   logic reset;
   logic                             csr_we;
   logic [pflh_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pflh_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pflh_req_if req_bus ();
   pflh_rsp_if rsp_bus ();

   pocket_floppy_link_handshake_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Link model: register copies and state, updated once per accepted request
   // ------------------------------------------------------------------------
   logic [7:0]  cfg_device_id  = pflh_pkg::DEVICE_ID_RESET;
   logic [7:0]  cfg_start_hold = pflh_pkg::START_HOLD_RESET;
   logic [9:0]  cfg_flush_idle = pflh_pkg::FLUSH_IDLE_RESET;

   sel_phase_type sel_phase = SEL_IDLE;
   logic [7:0]  sel_shift   = '0;
   logic [2:0]  sel_bits    = '0;
   logic [7:0]  sel_code    = '0;
   logic        ack_line    = 1'b0;
   logic        busy_seen   = 1'b0;
   logic [9:0]  ms_event    = '0;
   logic [11:0] ms_activity = pflh_pkg::LED_MS;
   logic        rx_odd      = 1'b0;
   logic [3:0]  rx_low      = '0;
   logic        rx_open     = 1'b0;
   logic        tx_odd      = 1'b0;
   logic [7:0]  tx_bytes[$];

   pflh_pkg::rsp_type expected_rsp[$];

   int  mismatch_count = 0;
   int  resp_seen      = 0;
   int  sent_items     = 0;
   int  idle_cycles    = 0;
   int  rsp_hold       = 0;
   int  rsp_stall      = 0;
   bit  traffic_gaps   = 1'b0;

   // Advance the link by one request and return the response it must give.
   function automatic pflh_pkg::rsp_type link_step(input pflh_pkg::req_type rq);
      pflh_pkg::rsp_type rs;
      logic       rise;
      logic       fall;
      logic [3:0] nib;
      logic [3:0] drv;
      logic [7:0] head;
      rs  = '0;
      drv = '0;
      // Time moves first, whatever the request is.
      if (rq.tick_ms) begin
         if (ms_event < pflh_pkg::EVT_MAX) ms_event++;
         if (ms_activity < pflh_pkg::LED_MS) ms_activity++;
      end
      if (rq.action) begin
         // Load: only the queue moves; a full queue drops the byte.
         if (tx_bytes.size() < pflh_pkg::QUEUE_DEPTH_DEFAULT)
            tx_bytes.push_back(rq.response_byte);
         else rs.queue_full = 1'b1;
      end else begin
         rise = rq.line_busy & ~busy_seen;
         fall = ~rq.line_busy & busy_seen;
         nib  = {rq.pin_data_in, rq.pin_data_out, rq.line_sel2, rq.line_sel1};
         if (sel_phase != SEL_IDLE) ms_activity = '0;
         case (sel_phase)
            SEL_IDLE: begin
               if (rq.pin_motor_out1 && rq.pin_data_out) begin
                  ms_event  = '0;
                  sel_phase = SEL_HOLD;
               end
            end
            SEL_HOLD: begin
               if (!(rq.pin_motor_out1 && rq.pin_data_out)) begin
                  sel_phase = SEL_IDLE;
               end else if (ms_event > cfg_start_hold) begin
                  sel_phase = SEL_BIT;
                  ack_line  = 1'b1;
               end
            end
            SEL_BIT: begin
               if (rq.line_busy) begin
                  sel_shift = {rq.pin_data_out, sel_shift[7:1]};
                  sel_bits  = sel_bits + 3'd1;
                  ack_line  = 1'b0;
                  if (sel_bits == 3'd0) begin
                     sel_code  = sel_shift;
                     sel_phase = (sel_code == cfg_device_id) ? SEL_MATCHED : SEL_IDLE;
                  end else begin
                     sel_phase = SEL_GAP;
                     ms_event  = '0;
                  end
               end
            end
            SEL_GAP: begin
               if (ms_event > pflh_pkg::ACK_GAP_MS) begin
                  sel_phase = SEL_BIT;
                  ack_line  = 1'b1;
               end
            end
            SEL_MATCHED: begin
               if (!rq.line_busy && !rq.pin_motor_out1) begin
                  ack_line  = 1'b1;
                  sel_phase = SEL_END_PULSE;
                  ms_event  = '0;
                  sel_shift = '0;
                  sel_bits  = '0;
               end
            end
            SEL_END_PULSE: begin
               if (ms_event > pflh_pkg::END_PULSE_MS) begin
                  ack_line  = 1'b0;
                  sel_phase = SEL_IDLE;
               end
            end
            default: sel_phase = SEL_IDLE;
         endcase

         // Nibble exchange, only while selected under the current device code.
         if (sel_code == cfg_device_id && sel_phase == SEL_IDLE) begin
            if (rise && !ack_line) begin
               if (rx_odd) begin
                  rs.rx_byte  = {nib, rx_low};
                  rs.rx_valid = 1'b1;
                  rx_odd      = 1'b0;
               end else begin
                  rx_low = nib;
                  rx_odd = 1'b1;
               end
               rx_open     = 1'b1;
               ack_line    = 1'b1;
               ms_event    = '0;
               ms_activity = '0;
            end else if (fall && ack_line) begin
               ack_line    = 1'b0;
               ms_event    = '0;
               ms_activity = '0;
            end else if (tx_bytes.size() != 0 && ms_event > pflh_pkg::TX_GAP_MS
                         && !rq.line_busy && !ack_line) begin
               head = tx_bytes[0];
               if (tx_odd) begin
                  drv = head[7:4];
                  tx_bytes.delete(0);
                  tx_odd = 1'b0;
               end else begin
                  drv    = head[3:0];
                  tx_odd = 1'b1;
               end
               rs.drive_valid = 1'b1;
               ack_line       = 1'b1;
               ms_activity    = '0;
            end else if (ack_line && rise) begin
               ack_line    = 1'b0;
               ms_activity = '0;
            end else if (ms_event > cfg_flush_idle && rx_open) begin
               // Idle gap closes the command and drops any unpaired nibble.
               rs.command_end = 1'b1;
               rx_open        = 1'b0;
               rx_odd         = 1'b0;
               ms_activity    = '0;
            end
         end
         busy_seen = rq.line_busy;
      end
      rs.ack_level      = ack_line;
      rs.drive_sel1     = drv[0];
      rs.drive_sel2     = drv[1];
      rs.drive_data_out = drv[2];
      rs.drive_data_in  = drv[3];
      rs.activity_led   = (ms_activity < pflh_pkg::LED_MS);
      return rs;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch in %s on response %0d: got 0x%0h, want 0x%0h",
               what, resp_seen, got, want);
      mismatch_count++;
   endtask

   // Predict at request acceptance, compare at response acceptance. Both are
   // sampled at the rising edge; the testbench only moves inputs on the fall.
   always @(posedge clock) begin
      pflh_pkg::rsp_type got;
      pflh_pkg::rsp_type want;
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            expected_rsp.push_back(link_step(req_bus.payload));
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = rsp_bus.payload;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", got, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (got.ack_level !== want.ack_level)
                  report_mismatch("ack_level", got.ack_level, want.ack_level);
               if (got.drive_valid !== want.drive_valid)
                  report_mismatch("drive_valid", got.drive_valid, want.drive_valid);
               if (got.drive_sel1 !== want.drive_sel1)
                  report_mismatch("drive_sel1", got.drive_sel1, want.drive_sel1);
               if (got.drive_sel2 !== want.drive_sel2)
                  report_mismatch("drive_sel2", got.drive_sel2, want.drive_sel2);
               if (got.drive_data_out !== want.drive_data_out)
                  report_mismatch("drive_data_out", got.drive_data_out, want.drive_data_out);
               if (got.drive_data_in !== want.drive_data_in)
                  report_mismatch("drive_data_in", got.drive_data_in, want.drive_data_in);
               if (got.rx_valid !== want.rx_valid)
                  report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
               if (got.rx_byte !== want.rx_byte)
                  report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
               if (got.command_end !== want.command_end)
                  report_mismatch("command_end", got.command_end, want.command_end);
               if (got.activity_led !== want.activity_led)
                  report_mismatch("activity_led", got.activity_led, want.activity_led);
               if (got.queue_full !== want.queue_full)
                  report_mismatch("queue_full", got.queue_full, want.queue_full);
            end
            resp_seen++;
         end
      end
   end

   // Watchdog: count edges at which neither side hands anything over.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      return ($urandom_range(0, 15) == 0) ? int'($urandom_range(8, 40))
                                          : int'($urandom_range(1, 3));
   endfunction

   // Response side: a long hold-off when a test asks for one, else random
   // stalls while gaps are enabled, else always ready.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold--;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready = 1'b1;
         if (traffic_gaps && $urandom_range(0, 4) == 0) rsp_stall = gap_len();
      end
   end

   // ------------------------------------------------------------------------
   // Request builders and drivers
   // ------------------------------------------------------------------------
   // Pin sample; nib carries SEL1, SEL2, D_OUT, D_IN as bits 0 to 3.
   function automatic pflh_pkg::req_type pin_sample(input logic busy, input logic mt1,
                                                    input logic tick,
                                                    input logic [3:0] nib);
      pflh_pkg::req_type rq;
      rq.action         = 1'b0;
      rq.line_busy      = busy;
      rq.pin_motor_out1 = mt1;
      rq.tick_ms        = tick;
      {rq.pin_data_in, rq.pin_data_out, rq.line_sel2, rq.line_sel1} = nib;
      rq.response_byte  = 8'($urandom);
      return rq;
   endfunction

   // Queue load; the pin fields are junk the core must ignore.
   function automatic pflh_pkg::req_type load_byte(input logic [7:0] value,
                                                   input logic tick);
      pflh_pkg::req_type rq;
      rq               = pin_sample(1'($urandom), 1'($urandom), tick, 4'($urandom));
      rq.action        = 1'b1;
      rq.response_byte = value;
      return rq;
   endfunction

   // Offer one request from the falling edge and hold it until taken.
   task automatic send_request(input pflh_pkg::req_type item);
      int gap;
      gap = (traffic_gaps && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   = 1'b1;
      req_bus.payload = item;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_items++;
   endtask

   // Drop valid and hold until every predicted response is back.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pflh_pkg::CSR_INDEX_W-1:0] index,
                            input logic [9:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         pflh_pkg::CSR_DEVICE_ID:     cfg_device_id  = value[7:0];
         pflh_pkg::CSR_START_HOLD_MS: cfg_start_hold = value[7:0];
         pflh_pkg::CSR_FLUSH_IDLE_MS: cfg_flush_idle = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Registers change only with the core quiet.
   task automatic apply_settings(input logic [7:0] dev, input logic [7:0] hold,
                                 input logic [9:0] flush);
      wait_drained();
      write_csr(pflh_pkg::CSR_DEVICE_ID, {2'b00, dev});
      write_csr(pflh_pkg::CSR_START_HOLD_MS, {2'b00, hold});
      write_csr(pflh_pkg::CSR_FLUSH_IDLE_MS, flush);
   endtask

   // Full selection: hold both lines, clock out the code LSB first with the
   // ACK gaps, release, then sit out the closing ACK pulse.
   task automatic select_device(input logic [7:0] code);
      repeat (cfg_start_hold + 2)
         send_request(pin_sample(1'b0, 1'b1, 1'b1, 4'($urandom) | 4'b0100));
      for (int b = 0; b < 8; b++) begin
         send_request(pin_sample(1'b1, 1'($urandom), 1'($urandom),
                                 code[b] ? (4'($urandom) | 4'b0100)
                                         : (4'($urandom) & 4'b1011)));
         if (b < 7)
            repeat (3) send_request(pin_sample(1'b0, 1'($urandom), 1'b1, 4'($urandom)));
      end
      send_request(pin_sample(1'b0, 1'b0, 1'($urandom), 4'($urandom)));
      repeat (10) send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'($urandom)));
   endtask

   // Host writes nibbles on rising BUSY; ticks are rare so writes win.
   task automatic host_write(input int nibbles);
      logic tick;
      repeat (nibbles) begin
         tick = ($urandom_range(0, 7) == 0);
         send_request(pin_sample(1'b1, 1'b0, tick, 4'($urandom)));
         send_request(pin_sample(1'b0, 1'b0, tick, 4'($urandom)));
      end
   endtask

   // Host lets the gap pass, then toggles BUSY to pull response nibbles.
   task automatic host_read(input int nibbles);
      repeat (6) send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'($urandom)));
      repeat (nibbles) begin
         send_request(pin_sample(1'b1, 1'b0, 1'($urandom), 4'($urandom)));
         send_request(pin_sample(1'b0, 1'b0, 1'($urandom), 4'($urandom)));
      end
   endtask

   // Mostly well-formed link traffic with random content, some noise.
   task automatic run_link_traffic(input int count);
      int      stop;
      int      kind;
      pflh_pkg::req_type junk;
      stop = sent_items + count;
      while (sent_items < stop) begin
         traffic_gaps = ($urandom_range(0, 3) != 0);
         kind         = $urandom_range(0, 19);
         if (kind < 5) begin
            select_device(($urandom_range(0, 3) != 0) ? cfg_device_id : 8'($urandom));
         end else if (kind < 11) begin
            host_write($urandom_range(1, 6));
         end else if (kind < 15) begin
            host_read($urandom_range(1, 8));
         end else if (kind < 17) begin
            repeat ($urandom_range(1, 6)) send_request(load_byte(8'($urandom), 1'($urandom)));
         end else if (kind == 17) begin
            // Idle gap long enough to close a command, capped for long settings.
            repeat ((cfg_flush_idle < 40) ? cfg_flush_idle + 2 : 40)
               send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'($urandom)));
         end else if (kind == 18) begin
            // Broken hold: both lines drop before the hold time is up.
            repeat ($urandom_range(1, cfg_start_hold))
               send_request(pin_sample(1'b0, 1'b1, 1'b1, 4'($urandom) | 4'b0100));
            send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'($urandom)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               junk        = pin_sample(1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
               junk.action = 1'($urandom);
               send_request(junk);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Device code 0 matches the reset selection, so the exchange runs at once.
   task automatic test_directed_fields();
      pflh_pkg::req_type rq;
      apply_settings(8'h00, 8'd1, 10'd1);
      send_request(load_byte(8'h00, 1'b1));
      send_request(load_byte(8'hFF, 1'b0));
      // Host byte 0x0F: low nibble all ones, high nibble all zeros.
      send_request(pin_sample(1'b1, 1'b0, 1'b0, 4'hF));
      send_request(pin_sample(1'b0, 1'b0, 1'b0, 4'h0));
      send_request(pin_sample(1'b1, 1'b0, 1'b0, 4'h0));
      send_request(pin_sample(1'b0, 1'b0, 1'b0, 4'h0));
      // Two ticks close the command, four more open the response gap.
      repeat (6) send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'h0));
      // Pull all four response nibbles.
      repeat (3) begin
         send_request(pin_sample(1'b1, 1'b0, 1'b0, 4'h0));
         send_request(pin_sample(1'b0, 1'b0, 1'b0, 4'h0));
      end
      send_request(pin_sample(1'b1, 1'b0, 1'b0, 4'h0));
      // Every pin field and the response byte at its top, then every field at zero.
      rq               = pin_sample(1'b1, 1'b1, 1'b1, 4'hF);
      rq.response_byte = 8'hFF;
      send_request(rq);
      rq               = pin_sample(1'b0, 1'b0, 1'b0, 4'h0);
      rq.response_byte = 8'h00;
      send_request(rq);
   endtask

   // The activity counter leaves reset at its ceiling and ticks must hold it
   // there. Then open a command with flush at its top so that passing time
   // never ends it, and lower flush to close it.
   task automatic test_counter_saturation();
      traffic_gaps = 1'b0;
      repeat (12)
         send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'($urandom) & 4'b1011));
      apply_settings(8'h00, 8'd1, 10'd1023);
      send_request(pin_sample(1'b1, 1'b0, 1'b0, 4'($urandom)));
      send_request(pin_sample(1'b0, 1'b0, 1'b0, 4'($urandom)));
      repeat (24)
         send_request(pin_sample(1'b0, 1'($urandom), 1'b1, 4'($urandom) & 4'b1011));
      apply_settings(8'h00, 8'd1, 10'd1);
      send_request(pin_sample(1'b0, 1'b0, 1'b0, 4'($urandom) & 4'b1011));
   endtask

   task automatic test_device_selection();
      traffic_gaps = 1'b1;
      // Longest hold, matching code, then a short exchange.
      apply_settings(8'h5A, 8'd255, 10'd3);
      select_device(8'h5A);
      host_write(3);
      repeat (5) send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'($urandom)));
      // Wrong code: the exchange must stay silent.
      apply_settings(8'h5A, 8'd1, 10'd3);
      select_device(8'hA5);
      host_write(2);
      // Register change: the stored code now matches and the exchange resumes.
      apply_settings(8'hA5, 8'd1, 10'd3);
      host_write(2);
      // Hold dropped after one sample.
      send_request(pin_sample(1'b0, 1'b1, 1'b1, 4'b0100));
      send_request(pin_sample(1'b0, 1'b0, 1'b1, 4'b0000));
   endtask

   task automatic test_queue_full();
      int fill;
      traffic_gaps = 1'b1;
      wait_drained();
      fill = pflh_pkg::QUEUE_DEPTH_DEFAULT - tx_bytes.size() + 4;
      repeat (fill) send_request(load_byte(8'($urandom), 1'($urandom)));
   endtask

   // Hold the response side off while requests keep coming, then pause the
   // sender until everything has come back.
   task automatic test_output_backpressure();
      wait_drained();
      rsp_hold = LONG_HOLD_OFF;
      run_link_traffic(40);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      apply_settings(pflh_pkg::DEVICE_ID_RESET, pflh_pkg::START_HOLD_RESET,
                     pflh_pkg::FLUSH_IDLE_RESET);
      run_link_traffic(30);
      apply_settings(8'h00, 8'd1, 10'd1);
      run_link_traffic(50);
      repeat (2) begin
         apply_settings(8'($urandom), 8'($urandom_range(1, 12)), 10'($urandom_range(1, 60)));
         run_link_traffic(30);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_counter_saturation();
      test_directed_fields();
      test_device_selection();
      test_queue_full();
      test_output_backpressure();
      test_random_traffic();

      // Drain, then give stray responses a chance to show up.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
